// ===== rtl/plpd_pkg.sv =====
// Shared types and constants of the point to line projection and distance unit.
// Used by every module of the unit and by its port checker; depends on nothing.
`default_nettype none

package plpd_pkg;

	// Fixed point format of all coordinates.
	localparam int COORD_FRAC_BITS = 16;
	localparam int COORD_W         = 32;

	// Configuration register indexes.
	localparam logic [2:0] REG_POINT_X = 3'd0;
	localparam logic [2:0] REG_POINT_Y = 3'd1;
	localparam logic [2:0] REG_POINT_Z = 3'd2;
	localparam logic [2:0] REG_DIR_X   = 3'd3;
	localparam logic [2:0] REG_DIR_Y   = 3'd4;
	localparam logic [2:0] REG_DIR_Z   = 3'd5;

	// Reset direction is the unit Y axis.
	localparam logic [COORD_W-1:0] DIR_Y_RESET = COORD_W'(1) << COORD_FRAC_BITS;

	// Saturation limits.
	localparam logic [COORD_W-1:0] DIST_MAX = '1;
	localparam logic [COORD_W-1:0] POS_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
	localparam logic [COORD_W-1:0] NEG_MIN  = {1'b1, {(COORD_W-1){1'b0}}};

	// Pipeline geometry.
	localparam int FOOT_QBITS = 34;  // quotient bits of each foot offset
	localparam int DIST_QBITS = 64;  // quotient bits of the squared distance
	localparam int ROOT_BITS  = 32;  // result bits of the square root
	localparam int FRONT_LAST = 4;   // last stage shared by both paths
	localparam int FOOT_LAST  = FRONT_LAST + 2 + FOOT_QBITS + 1;
	localparam int DIV_BASE   = FRONT_LAST + 4;
	localparam int PIPE_LAST  = DIV_BASE + DIST_QBITS + ROOT_BITS;

	typedef struct packed {
		logic [COORD_W-1:0] query_x;
		logic [COORD_W-1:0] query_y;
		logic [COORD_W-1:0] query_z;
	} query_t;

	typedef struct packed {
		logic [COORD_W-1:0] foot_x;
		logic [COORD_W-1:0] foot_y;
		logic [COORD_W-1:0] foot_z;
		logic [COORD_W-1:0] distance;
		logic               on_line;
		logic               degenerate;
	} result_t;

endpackage

`default_nettype wire

// ===== rtl/point_line_projection_distance_unit.sv =====
// Top level of the point to line projection and distance unit.
// Depends on plpd_pkg and plpd_foot.
`default_nettype none

// The unit holds a 3D line as a point and a direction and takes one query point per
// cycle unless a waiting result stalls the pipeline. Each item gives the rounded
// perpendicular foot on the line, the floor of the distance to the line, an on-line
// flag and a flag for a zero direction. The distance comes from the 64-stage quotient
// of the squared distance and the 32-stage square root behind it; the foot path is
// delayed to match. All stages before the output register move on one enable, and an
// empty stage in front of it lets a new item in while a result waits to be taken.
// Configuration may be written only while no item is in flight.
module point_line_projection_distance_unit (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [2:0]        cfg_addr,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire plpd_pkg::query_t  in_data,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output plpd_pkg::result_t      out_data
);

	localparam int SF  = plpd_pkg::FOOT_LAST;
	localparam int SL  = plpd_pkg::PIPE_LAST;
	localparam int SD  = plpd_pkg::DIV_BASE;
	localparam int DQ  = plpd_pkg::DIST_QBITS;
	localparam int RB  = plpd_pkg::ROOT_BITS;
	localparam int S5  = plpd_pkg::FRONT_LAST + 1;

	// Configuration registers.
	logic [31:0] pnt_q [3];
	logic [31:0] dir_q [3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pnt_q[0] <= '0;
			pnt_q[1] <= '0;
			pnt_q[2] <= '0;
			dir_q[0] <= '0;
			dir_q[1] <= plpd_pkg::DIR_Y_RESET;
			dir_q[2] <= '0;
		end else if (cfg_we) begin
			case (cfg_addr)
				plpd_pkg::REG_POINT_X: pnt_q[0] <= cfg_wdata;
				plpd_pkg::REG_POINT_Y: pnt_q[1] <= cfg_wdata;
				plpd_pkg::REG_POINT_Z: pnt_q[2] <= cfg_wdata;
				plpd_pkg::REG_DIR_X:   dir_q[0] <= cfg_wdata;
				plpd_pkg::REG_DIR_Y:   dir_q[1] <= cfg_wdata;
				plpd_pkg::REG_DIR_Z:   dir_q[2] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	logic signed [31:0] pnt_c [3];
	logic signed [31:0] dir_c [3];
	logic signed [63:0] dsq_c [3];
	for (genvar i = 0; i < 3; i++) begin : g_cfg
		assign pnt_c[i] = pnt_q[i];
		assign dir_c[i] = dir_q[i];
		assign dsq_c[i] = dir_c[i] * dir_c[i];
	end

	// Squared direction length, updated after a write through the sq_q and then the dd_q registers.
	logic [62:0] sq_q [3];
	logic [63:0] dd_q;

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			sq_q[i] <= dsq_c[i][62:0];
		end
		dd_q <= {1'b0, sq_q[0]} + {1'b0, sq_q[1]} + {1'b0, sq_q[2]};
	end

	// Stage enables: the output register moves on its own handshake.
	logic [SL:1] v_s;
	logic        en;
	logic        out_en;
	assign out_en   = !out_valid || out_ready;
	assign en       = !v_s[SL] || out_en;
	assign in_ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s       <= '0;
			out_valid <= 1'b0;
		end else begin
			if (en) begin
				v_s <= {v_s[SL-1:1], in_valid};
			end
			if (out_en) begin
				out_valid <= v_s[SL];
			end
		end
	end

	// Stage 1: register the query.
	plpd_pkg::query_t q_s1;
	always_ff @(posedge clk) begin
		if (en) begin
			q_s1 <= in_data;
		end
	end

	logic signed [31:0] qa_s1 [3];
	assign qa_s1[0] = q_s1.query_x;
	assign qa_s1[1] = q_s1.query_y;
	assign qa_s1[2] = q_s1.query_z;

	// Stage 2: offset from the line point.
	logic signed [32:0] w_c  [3];
	logic signed [32:0] w_s2 [3];
	plpd_pkg::query_t   q_s2;
	for (genvar i = 0; i < 3; i++) begin : g_w
		assign w_c[i] = qa_s1[i] - pnt_c[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			w_s2 <= w_c;
			q_s2 <= q_s1;
		end
	end

	// Stage 3: dot product terms and cross product terms.
	logic signed [63:0] dot_c  [3];
	logic signed [63:0] cra_c  [3];
	logic signed [63:0] crb_c  [3];
	logic signed [63:0] dot_s3 [3];
	logic signed [63:0] cra_s3 [3];
	logic signed [63:0] crb_s3 [3];
	plpd_pkg::query_t   q_s3;

	for (genvar i = 0; i < 3; i++) begin : g_prod
		assign dot_c[i] = w_s2[i] * dir_c[i];
		assign cra_c[i] = w_s2[(i+1)%3] * dir_c[(i+2)%3];
		assign crb_c[i] = w_s2[(i+2)%3] * dir_c[(i+1)%3];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dot_s3 <= dot_c;
			cra_s3 <= cra_c;
			crb_s3 <= crb_c;
			q_s3   <= q_s2;
		end
	end

	// Stage 4: dot product as sign and magnitude, cross product magnitudes.
	logic signed [65:0] dsum_c;
	logic signed [65:0] dnegv_c;
	logic signed [64:0] cd_c  [3];
	logic signed [64:0] cdn_c [3];
	logic [64:0]        sabs_s4;
	logic               sneg_s4;
	logic [63:0]        cm_s4 [3];
	logic               deg_s4;
	plpd_pkg::query_t   q_s4;

	assign dsum_c  = dot_s3[0] + dot_s3[1] + dot_s3[2];
	assign dnegv_c = -dsum_c;
	for (genvar i = 0; i < 3; i++) begin : g_cd
		assign cd_c[i]  = cra_s3[i] - crb_s3[i];
		assign cdn_c[i] = -cd_c[i];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sneg_s4 <= dsum_c[65];
			sabs_s4 <= dsum_c[65] ? dnegv_c[64:0] : dsum_c[64:0];
			for (int i = 0; i < 3; i++) begin
				cm_s4[i] <= cd_c[i][64] ? cdn_c[i][63:0] : cd_c[i][63:0];
			end
			deg_s4 <= (dd_q == '0);
			q_s4   <= q_s3;
		end
	end

	// Foot path, one unit per axis.
	logic [31:0] qa_s4   [3];
	logic [31:0] foot_c  [3];
	assign qa_s4[0] = q_s4.query_x;
	assign qa_s4[1] = q_s4.query_y;
	assign qa_s4[2] = q_s4.query_z;

	for (genvar i = 0; i < 3; i++) begin : g_foot
		plpd_foot u_foot (
			.clk  (clk),
			.en   (en),
			.sabs (sabs_s4),
			.sneg (sneg_s4),
			.q    (qa_s4[i]),
			.deg  (deg_s4),
			.pnt  (pnt_q[i]),
			.dir  (dir_q[i]),
			.dd   (dd_q),
			.foot (foot_c[i])
		);
	end

	// Delay the feet until the distance is ready.
	logic [95:0] feet_s [SF+1:SL];
	always_ff @(posedge clk) begin
		if (en) begin
			feet_s[SF+1] <= {foot_c[0], foot_c[1], foot_c[2]};
			for (int k = SF + 2; k <= SL; k++) begin
				feet_s[k] <= feet_s[k-1];
			end
		end
	end

	// Degenerate flag travels down the distance path.
	logic deg_s [S5:SL];
	always_ff @(posedge clk) begin
		if (en) begin
			deg_s[S5] <= deg_s4;
			for (int k = S5 + 1; k <= SL; k++) begin
				deg_s[k] <= deg_s[k-1];
			end
		end
	end

	// Stage 5: partial products of each squared cross component.
	logic [63:0] hh_s5 [3];
	logic [63:0] hl_s5 [3];
	logic [63:0] ll_s5 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				hh_s5[i] <= {32'd0, cm_s4[i][63:32]} * {32'd0, cm_s4[i][63:32]};
				hl_s5[i] <= {32'd0, cm_s4[i][63:32]} * {32'd0, cm_s4[i][31:0]};
				ll_s5[i] <= {32'd0, cm_s4[i][31:0]} * {32'd0, cm_s4[i][31:0]};
			end
		end
	end

	// Stage 6: each squared component.
	logic [127:0] sq_s6 [3];
	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				sq_s6[i] <= {hh_s5[i], 64'd0} + {31'd0, hl_s5[i], 33'd0}
					+ {64'd0, ll_s5[i]};
			end
		end
	end

	// Stage 7: squared length of the cross product.
	logic [129:0] acc_s7;
	always_ff @(posedge clk) begin
		if (en) begin
			acc_s7 <= {2'd0, sq_s6[0]} + {2'd0, sq_s6[1]} + {2'd0, sq_s6[2]};
		end
	end

	// Stage 8: saturation test and start of the division by dd.
	logic [63:0] drem_s [0:DQ];
	logic [63:0] dz_s   [0:DQ];
	logic        sat_s  [SD:SL];

	always_ff @(posedge clk) begin
		if (en) begin
			sat_s[SD] <= acc_s7[129:64] >= {2'd0, dd_q};
			drem_s[0] <= acc_s7[127:64];
			dz_s[0]   <= acc_s7[63:0];
			for (int k = SD + 1; k <= SL; k++) begin
				sat_s[k] <= sat_s[k-1];
			end
		end
	end

	// Restoring division of the squared cross length by dd, one bit per stage.
	for (genvar k = 1; k <= DQ; k++) begin : g_ddiv
		logic [64:0] trial_c;
		logic [64:0] diff_c;
		logic        ge_c;
		assign trial_c = {drem_s[k-1], dz_s[k-1][DQ-1]};
		assign diff_c  = trial_c - {1'b0, dd_q};
		assign ge_c    = trial_c >= {1'b0, dd_q};

		always_ff @(posedge clk) begin
			if (en) begin
				drem_s[k] <= ge_c ? diff_c[63:0] : trial_c[63:0];
				dz_s[k]   <= {dz_s[k-1][DQ-2:0], ge_c};
			end
		end
	end

	// Integer square root, one result bit per stage.
	logic [RB-1:0] root_s [0:RB];
	logic [32:0]   srem_s [0:RB];
	logic [63:0]   sx_s   [0:RB];
	assign root_s[0] = '0;
	assign srem_s[0] = '0;
	assign sx_s[0]   = dz_s[DQ];

	for (genvar j = 1; j <= RB; j++) begin : g_sqrt
		logic [34:0] r2_c;
		logic [34:0] trial_c;
		logic [34:0] diff_c;
		logic        ge_c;
		assign r2_c    = {srem_s[j-1], sx_s[j-1][63:62]};
		assign trial_c = {1'b0, root_s[j-1], 2'b01};
		assign diff_c  = r2_c - trial_c;
		assign ge_c    = r2_c >= trial_c;

		always_ff @(posedge clk) begin
			if (en) begin
				srem_s[j] <= ge_c ? diff_c[32:0] : r2_c[32:0];
				root_s[j] <= {root_s[j-1][RB-2:0], ge_c};
				sx_s[j]   <= {sx_s[j-1][61:0], 2'b00};
			end
		end
	end

	// Output register: final distance selection and flags.
	logic [31:0] dist_c;
	always_comb begin
		if (deg_s[SL]) begin
			dist_c = '0;
		end else if (sat_s[SL]) begin
			dist_c = plpd_pkg::DIST_MAX;
		end else begin
			dist_c = root_s[RB];
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			out_data.foot_x     <= feet_s[SL][95:64];
			out_data.foot_y     <= feet_s[SL][63:32];
			out_data.foot_z     <= feet_s[SL][31:0];
			out_data.distance   <= dist_c;
			out_data.on_line    <= !deg_s[SL] && (dist_c == '0);
			out_data.degenerate <= deg_s[SL];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/plpd_foot.sv =====
// One axis of the perpendicular foot: scaled dot product, rounded division, offset and clamp.
// Depends on plpd_pkg; advanced by the shared stage enable of the top level.
`default_nettype none

module plpd_foot (
	input  wire logic        clk,
	input  wire logic        en,
	input  wire logic [64:0] sabs,
	input  wire logic        sneg,
	input  wire logic [31:0] q,
	input  wire logic        deg,
	input  wire logic [31:0] pnt,
	input  wire logic [31:0] dir,
	input  wire logic [63:0] dd,
	output logic      [31:0] foot
);

	localparam int QB   = plpd_pkg::FOOT_QBITS;
	localparam int S6   = plpd_pkg::FRONT_LAST + 2;
	localparam int SEND = S6 + QB;

	// Magnitude of the direction component.
	logic [31:0] dneg_c;
	logic [31:0] dmag_c;
	assign dneg_c = -dir;
	assign dmag_c = dir[31] ? dneg_c : dir;

	// Stage 5: two partial products of |s| * |d|.
	logic [64:0] plo_s5;
	logic [63:0] phi_s5;
	logic        neg_s5;
	logic [31:0] q_s5;
	logic        deg_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			plo_s5 <= {32'd0, sabs[32:0]} * {33'd0, dmag_c};
			phi_s5 <= {32'd0, sabs[64:33]} * {32'd0, dmag_c};
			neg_s5 <= sneg ^ dir[31];
			q_s5   <= q;
			deg_s5 <= deg;
		end
	end

	// Stage 6: numerator 2*|s|*|d| + dd of the rounded quotient.
	logic [96:0] prod_c;
	logic [96:0] num_c;
	assign prod_c = {phi_s5, 33'd0} + {32'd0, plo_s5};
	assign num_c  = {prod_c[95:0], 1'b0} + {33'd0, dd};

	logic [64:0]   rem_s [0:QB];
	logic [QB-1:0] z_s   [0:QB];
	logic [31:0]   q_s   [S6:SEND];
	logic          deg_s [S6:SEND];
	logic          neg_s [S6:SEND];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= {2'd0, num_c[96:QB]};
			z_s[0]    <= num_c[QB-1:0];
			q_s[S6]   <= q_s5;
			deg_s[S6] <= deg_s5;
			neg_s[S6] <= neg_s5;
		end
	end

	// Restoring division by 2*dd, one quotient bit per stage.
	logic [64:0] den_c;
	assign den_c = {dd, 1'b0};

	for (genvar k = 1; k <= QB; k++) begin : g_div
		logic [65:0] trial_c;
		logic [65:0] diff_c;
		logic        ge_c;
		assign trial_c = {rem_s[k-1], z_s[k-1][QB-1]};
		assign diff_c  = trial_c - {1'b0, den_c};
		assign ge_c    = trial_c >= {1'b0, den_c};

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k]     <= ge_c ? diff_c[64:0] : trial_c[64:0];
				z_s[k]       <= {z_s[k-1][QB-2:0], ge_c};
				q_s[S6+k]    <= q_s[S6+k-1];
				deg_s[S6+k]  <= deg_s[S6+k-1];
				neg_s[S6+k]  <= neg_s[S6+k-1];
			end
		end
	end

	// Final stage: apply the signed offset to the line point and clamp, or pass the query on a zero direction.
	logic signed [35:0] pext_c;
	logic signed [35:0] off_c;
	logic signed [35:0] sum_c;
	logic        [31:0] clamp_c;
	assign pext_c = {{4{pnt[31]}}, pnt};
	assign off_c  = {2'd0, z_s[QB]};
	assign sum_c  = neg_s[SEND] ? (pext_c - off_c) : (pext_c + off_c);

	always_comb begin
		if (sum_c > 36'sh0_7FFF_FFFF) begin
			clamp_c = plpd_pkg::POS_MAX;
		end else if (sum_c < -36'sh0_8000_0000) begin
			clamp_c = plpd_pkg::NEG_MIN;
		end else begin
			clamp_c = sum_c[31:0];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			foot <= deg_s[SEND] ? q_s[SEND] : clamp_c;
		end
	end

endmodule

`default_nettype wire

// ===== rtl/plpd_check.sv =====
// Port checker of the point to line projection and distance unit, and its bind.
// Depends on plpd_pkg; sees only the ports of the top level.
`default_nettype none

module plpd_check (
	input wire logic              clk,
	input wire logic              arst_n,
	input wire logic              cfg_we,
	input wire logic [2:0]        cfg_addr,
	input wire logic [31:0]       cfg_wdata,
	input wire logic              in_valid,
	input wire logic              in_ready,
	input wire plpd_pkg::query_t  in_data,
	input wire logic              out_valid,
	input wire logic              out_ready,
	input wire plpd_pkg::result_t out_data
);

	// A waiting result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");

	// An empty output never blocks the input side.
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty output");

	// A zero direction gives zero distance and never an on-line item.
	a_deg: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.degenerate |-> out_data.distance == '0 && !out_data.on_line)
		else $error("degenerate item with distance or on-line flag");

	// On a proper line the on-line flag is exactly a zero distance.
	a_online: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.degenerate |->
			out_data.on_line == (out_data.distance == '0))
		else $error("on-line flag disagrees with distance");

endmodule

bind point_line_projection_distance_unit plpd_check u_plpd_check (.*);

`default_nettype wire
